// ===== rtl/sspq_pkg.sv =====
// Package for the stable sorted priority queue.
// Holds the entry and control types and the mode and status codes.
// Used by sspq_cell and stable_sorted_priority_queue; depends on nothing.
package sspq_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int DATA_W           = 32;
    localparam int COUNT_OUT_W      = 8;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_CLR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_ENQ = 2'd0,
        ST_DEQ = 2'd1,
        ST_REJ = 2'd2,
        ST_CLR = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } ctrl_t;

endpackage

// ===== rtl/stable_sorted_priority_queue.sv =====
// Top level of the stable sorted priority queue: a row of cells plus count and result register.
// Depends on sspq_pkg and sspq_cell.
//
// The queue keeps up to CAPACITY entries in a row of cells sorted by ascending priority,
// equal priorities in arrival order. Every cell compares its entry with the new word at
// once, so enqueue, dequeue and clear are each done as the word is accepted: a word is accepted in every
// cycle in which the result register is empty or being read, and its result is registered
// and appears in the next cycle. The cell comparison against the broadcast priority sets the clock.
module stable_sorted_priority_queue
#(
    parameter int CAPACITY = sspq_pkg::DEFAULT_CAPACITY
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            mode,
    input  logic signed [sspq_pkg::DATA_W-1:0]    item_value,
    input  logic signed [sspq_pkg::DATA_W-1:0]    item_priority,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [1:0]                            status,
    output logic                                  out_valid,
    output logic signed [sspq_pkg::DATA_W-1:0]    out_value,
    output logic signed [sspq_pkg::DATA_W-1:0]    out_priority,
    output logic                                  is_empty,
    output logic                                  is_full,
    output logic [sspq_pkg::COUNT_OUT_W-1:0]      entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              res_valid_reg;
    sspq_pkg::status_t status_reg;
    sspq_pkg::status_t status_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sspq_pkg::entry_t  head_reg;
    sspq_pkg::entry_t  head_next;

    logic              fire;
    logic              full;
    logic              empty;
    sspq_pkg::ctrl_t   ctrl;

    sspq_pkg::entry_t  cell_entry [CAPACITY];
    logic              cell_after [CAPACITY];

    assign in_ready = !res_valid_reg || res_ready;
    assign fire     = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        ctrl.enq       = 1'b0;
        ctrl.deq       = 1'b0;
        ctrl.item      = '{value: item_value, prio: item_priority};
        count_next     = count_reg;
        status_next    = sspq_pkg::ST_REJ;
        out_valid_next = 1'b0;
        head_next      = '0;
        unique case (sspq_pkg::mode_t'(mode))
            sspq_pkg::MODE_ENQ:
            begin
                if (!full)
                begin
                    ctrl.enq    = fire;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = sspq_pkg::ST_ENQ;
                end
            end
            sspq_pkg::MODE_DEQ:
            begin
                if (!empty)
                begin
                    ctrl.deq       = fire;
                    count_next     = count_reg - CNT_W'(1);
                    status_next    = sspq_pkg::ST_DEQ;
                    out_valid_next = 1'b1;
                    head_next      = cell_entry[0];
                end
            end
            sspq_pkg::MODE_CLR:
            begin
                count_next  = '0;
                status_next = sspq_pkg::ST_CLR;
            end
            default:
            begin
                status_next = sspq_pkg::ST_REJ;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             left_after;
        sspq_pkg::entry_t left_entry;
        sspq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_after = 1'b0;
            assign left_entry = ctrl.item;
        end
        else
        begin : g_inner
            assign left_after = cell_after[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        sspq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .left_after  (left_after),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .after       (cell_after[i]),
            .entry       (cell_entry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign out_valid    = out_valid_reg;
    assign out_value    = head_reg.value;
    assign out_priority = head_reg.prio;
    assign is_empty     = empty;
    assign is_full      = full;
    assign entry_count  = sspq_pkg::COUNT_OUT_W'(count_reg);

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (mode == sspq_pkg::MODE_CLR)) |=> (count_reg == '0))
        else $error("Clear did not empty the queue.");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("Accepted word produced no result.");

    a_dequeue_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctrl.deq) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("Dequeue did not reduce the count by one.");
`endif

endmodule

// ===== rtl/sspq_cell.sv =====
// One cell of the sorted chain: holds one entry and decides each cycle whether
// to keep it, take its left neighbour's, take the new word or take its right neighbour's.
// Depends on sspq_pkg.
module sspq_cell
(
    input  logic            clk,
    input  sspq_pkg::ctrl_t ctrl,
    input  logic            occupied,
    input  logic            left_after,
    input  sspq_pkg::entry_t left_entry,
    input  sspq_pkg::entry_t right_entry,
    output logic            after,
    output sspq_pkg::entry_t entry
);

    sspq_pkg::entry_t entry_reg;
    sspq_pkg::entry_t entry_next;

    // The cell lies at or behind the insertion point unless it holds an entry
    // whose priority is no greater than the new one.
    assign after = !(occupied && (entry_reg.prio <= ctrl.item.prio));
    assign entry = entry_reg;

    always_comb
    begin
        priority if (ctrl.enq && after)
        begin
            entry_next = left_after ? left_entry : ctrl.item;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the stable sorted priority queue.
// Drives enqueue, dequeue, clear and unused-mode words through the valid/ready ports and
// checks every result against a behavioural queue model. Depends on sspq_pkg and the RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY     = sspq_pkg::DEFAULT_CAPACITY;
    localparam logic [1:0]  MODE_NONE    = 2'd3;
    localparam int          RANDOM_WORDS = 1150;
    localparam int          IDLE_PERCENT = 13;
    localparam int          QUIET_FIRST  = 400;
    localparam int          QUIET_LAST   = 900;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          REPORT_LIMIT = 40;

    typedef struct {
        logic [1:0]                         mode;
        logic signed [sspq_pkg::DATA_W-1:0] value;
        logic signed [sspq_pkg::DATA_W-1:0] prio;
        bit                                 drain_first;
    } pending_word_t;

    typedef struct packed {
        logic [1:0]                           status;
        logic                                 valid;
        logic signed [sspq_pkg::DATA_W-1:0]   value;
        logic signed [sspq_pkg::DATA_W-1:0]   prio;
        logic                                 empty;
        logic                                 full;
        logic [sspq_pkg::COUNT_OUT_W-1:0]     count;
    } outcome_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [1:0]                           mode;
    logic signed [sspq_pkg::DATA_W-1:0]   item_value;
    logic signed [sspq_pkg::DATA_W-1:0]   item_priority;
    logic                                 res_valid;
    logic                                 res_ready;
    logic [1:0]                           status;
    logic                                 out_valid;
    logic signed [sspq_pkg::DATA_W-1:0]   out_value;
    logic signed [sspq_pkg::DATA_W-1:0]   out_priority;
    logic                                 is_empty;
    logic                                 is_full;
    logic [sspq_pkg::COUNT_OUT_W-1:0]     entry_count;

    pending_word_t      pending_words[$];
    sspq_pkg::entry_t   held_entries[$];
    outcome_t           awaited_outcomes[$];
    int                 in_flight = 0;
    int                 cycle_count = 0;
    int                 error_count = 0;
    int                 results_seen = 0;
    int                 enqueued_seen = 0;
    int                 dequeued_seen = 0;
    int                 rejected_seen = 0;
    int                 cleared_seen = 0;
    int                 full_reached = 0;

    stable_sorted_priority_queue #(.CAPACITY(CAPACITY)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .status        (status),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .entry_count   (entry_count)
    );

    always #5 clk = ~clk;

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FIRST && cycle_count <= QUIET_LAST)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic outcome_t serve_word(input pending_word_t w);
        outcome_t         o;
        sspq_pkg::entry_t e;
        int               pos;
        o = '0;
        o.status = sspq_pkg::ST_REJ;
        case (w.mode)
            sspq_pkg::MODE_ENQ:
            begin
                if (held_entries.size() < CAPACITY)
                begin
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= w.prio)
                    begin
                        pos++;
                    end
                    e.value = w.value;
                    e.prio  = w.prio;
                    held_entries.insert(pos, e);
                    o.status = sspq_pkg::ST_ENQ;
                end
            end
            sspq_pkg::MODE_DEQ:
            begin
                if (held_entries.size() > 0)
                begin
                    e = held_entries.pop_front();
                    o.valid  = 1'b1;
                    o.value  = e.value;
                    o.prio   = e.prio;
                    o.status = sspq_pkg::ST_DEQ;
                end
            end
            sspq_pkg::MODE_CLR:
            begin
                held_entries.delete();
                o.status = sspq_pkg::ST_CLR;
            end
            default:
            begin
            end
        endcase
        o.empty = held_entries.size() == 0;
        o.full  = held_entries.size() == CAPACITY;
        o.count = sspq_pkg::COUNT_OUT_W'(held_entries.size());
        return o;
    endfunction

    task automatic report_mismatch(input string field,
                                   input logic [sspq_pkg::DATA_W-1:0] want,
                                   input logic [sspq_pkg::DATA_W-1:0] seen);
        if (error_count < REPORT_LIMIT)
        begin
            $display("Mismatch on result %0d, %s: expected 0x%h, got 0x%h",
                     results_seen, field, want, seen);
        end
        error_count++;
    endtask

    task automatic check_outcome(input outcome_t want);
        if (status !== want.status)
        begin
            report_mismatch("status", sspq_pkg::DATA_W'(want.status),
                            sspq_pkg::DATA_W'(status));
        end
        if (out_valid !== want.valid)
        begin
            report_mismatch("out_valid", sspq_pkg::DATA_W'(want.valid),
                            sspq_pkg::DATA_W'(out_valid));
        end
        if (out_value !== want.value)
        begin
            report_mismatch("out_value", want.value, out_value);
        end
        if (out_priority !== want.prio)
        begin
            report_mismatch("out_priority", want.prio, out_priority);
        end
        if (is_empty !== want.empty)
        begin
            report_mismatch("is_empty", sspq_pkg::DATA_W'(want.empty),
                            sspq_pkg::DATA_W'(is_empty));
        end
        if (is_full !== want.full)
        begin
            report_mismatch("is_full", sspq_pkg::DATA_W'(want.full),
                            sspq_pkg::DATA_W'(is_full));
        end
        if (entry_count !== want.count)
        begin
            report_mismatch("entry_count", sspq_pkg::DATA_W'(want.count),
                            sspq_pkg::DATA_W'(entry_count));
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("** stable_sorted_priority_queue: FAILED **");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            mode          <= sspq_pkg::MODE_ENQ;
            item_value    <= '0;
            item_priority <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_words.size() != 0 && !idle_now() &&
                (!pending_words[0].drain_first ||
                 (!in_valid && in_flight == 0 && !res_valid)))
            begin
                in_valid      <= 1'b1;
                mode          <= pending_words[0].mode;
                item_value    <= pending_words[0].value;
                item_priority <= pending_words[0].prio;
                void'(pending_words.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin : monitor
        pending_word_t w;
        outcome_t      want;
        bit            took_word;
        bit            gave_result;
        took_word   = rst_n && in_valid && in_ready;
        gave_result = rst_n && res_valid && res_ready;
        if (gave_result)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                report_mismatch("unexpected result, status", '0,
                                sspq_pkg::DATA_W'(status));
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_outcome(want);
                case (want.status)
                    sspq_pkg::ST_ENQ: enqueued_seen++;
                    sspq_pkg::ST_DEQ: dequeued_seen++;
                    sspq_pkg::ST_REJ: rejected_seen++;
                    default: cleared_seen++;
                endcase
                if (want.full && want.status == sspq_pkg::ST_ENQ)
                begin
                    full_reached++;
                end
            end
            results_seen++;
        end
        if (took_word)
        begin
            w.mode        = mode;
            w.value       = item_value;
            w.prio        = item_priority;
            w.drain_first = 1'b0;
            awaited_outcomes.push_back(serve_word(w));
        end
        in_flight <= in_flight + int'(took_word) - int'(gave_result);
    end

    task automatic add_word(input logic [1:0] m, input logic [sspq_pkg::DATA_W-1:0] v,
                            input logic [sspq_pkg::DATA_W-1:0] p, input bit drain_first);
        pending_word_t w;
        w.mode        = m;
        w.value       = v;
        w.prio        = p;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endtask

    function automatic logic [sspq_pkg::DATA_W-1:0] pick_priority();
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            return sspq_pkg::DATA_W'($urandom_range(7));
        end
        if (r == 4)
        begin
            return 32'h7fff_ffff - $urandom_range(3);
        end
        if (r == 5)
        begin
            return 32'h8000_0000 + $urandom_range(3);
        end
        return $urandom;
    endfunction

    initial
    begin
        int         random_words;
        int         segment;
        int         length;
        int         r;
        logic [1:0] m;

        // Directed opening: empty-queue corner cases, extreme fields and ties.
        add_word(sspq_pkg::MODE_DEQ, 32'h1234_5678, 32'h0000_0001, 1'b0);
        add_word(sspq_pkg::MODE_CLR, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        add_word(MODE_NONE, 32'h0, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'hffff_ffff, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h0000_0001, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h0000_0002, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h0000_0003, 32'hffff_ffff, 1'b0);
        add_word(MODE_NONE, 32'hdead_beef, 32'h8000_0000, 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            add_word(sspq_pkg::MODE_DEQ, $urandom, $urandom, 1'b0);
        end
        add_word(sspq_pkg::MODE_DEQ, 32'h0, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h5555_5555, 32'h0000_0005, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'haaaa_aaaa, 32'h0000_0004, 1'b0);
        add_word(sspq_pkg::MODE_CLR, 32'h0, 32'h0, 1'b1);
        add_word(sspq_pkg::MODE_DEQ, 32'h0, 32'h0, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
        add_word(sspq_pkg::MODE_ENQ, 32'hffff_ffff, 32'h8000_0000, 1'b0);

        // Random part: fill and drain runs that push the queue to both ends,
        // separated by mixed traffic.
        random_words = 0;
        segment = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (segment % 4 == 0 || segment % 4 == 2)
            begin
                length = $urandom_range(132, 140);
            end
            else
            begin
                length = $urandom_range(30, 60);
            end
            if (length > RANDOM_WORDS - random_words)
            begin
                length = RANDOM_WORDS - random_words;
            end
            for (int i = 0; i < length; i++)
            begin
                if (segment % 4 == 0)
                begin
                    m = sspq_pkg::MODE_ENQ;
                end
                else if (segment % 4 == 2)
                begin
                    m = sspq_pkg::MODE_DEQ;
                end
                else
                begin
                    r = $urandom_range(99);
                    m = r < 50 ? sspq_pkg::MODE_ENQ :
                        r < 88 ? sspq_pkg::MODE_DEQ :
                        r < 93 ? sspq_pkg::MODE_CLR : MODE_NONE;
                end
                add_word(m, $urandom, pick_priority(), i == 0 && $urandom_range(2) == 0);
            end
            random_words += length;
            segment++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || awaited_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Checked %0d results: %0d enqueued, %0d dequeued, %0d rejected, %0d cleared.",
                 results_seen, enqueued_seen, dequeued_seen, rejected_seen, cleared_seen);
        $display("The queue was filled to capacity %0d times; %0d mismatches.",
                 full_reached, error_count);
        if (error_count == 0)
        begin
            $display("** stable_sorted_priority_queue: PASSED **");
        end
        else
        begin
            $display("** stable_sorted_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule
